### rtl/itoaf_pkg.sv
// Shared types, codes and constants of the integer to ASCII formatter.
package itoaf_pkg;

    // Format kinds
    localparam logic [2:0] FUNC_S16    = 3'd0;
    localparam logic [2:0] FUNC_S32    = 3'd1;
    localparam logic [2:0] FUNC_U16    = 3'd2;
    localparam logic [2:0] FUNC_HEX_LO = 3'd3;
    localparam logic [2:0] FUNC_HEX_UP = 3'd4;
    localparam logic [2:0] FUNC_BYTE   = 3'd5;
    localparam logic [2:0] FUNC_EMPTY  = 3'd6;
    // spare code, formats as empty
    localparam logic [2:0] FUNC_RSVD   = 3'd7;

    localparam logic [3:0] MAX_WIDTH  = 4'd9;
    localparam int         NUM_DIGITS = 10;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_UC_A  = 8'h41;

    localparam logic [5:0] BITS_16 = 6'd16;
    localparam logic [5:0] BITS_32 = 6'd32;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  func;
        logic [3:0]  width;
        logic        zero_fill;
    } t_req;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_res;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_DABBLE,
        OP_COUNT,
        OP_EMIT_SIGN,
        OP_EMIT_PAD,
        OP_EMIT_DIG
    } t_op;

    typedef enum logic [3:0] {
        C_NONE,
        C_ALWAYS,
        C_WAIT,
        C_CONV_DONE,
        C_BITS_LEFT,
        C_NO_LEAD,
        C_PAD_ZERO,
        C_PAD_LEFT,
        C_NO_TRAIL,
        C_DIG_ZERO,
        C_DIG_LEFT
    } t_cond;

    typedef logic [3:0] t_upc;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_upc  target;
    } t_uword;

    // Datapath flags seen by the jump logic
    typedef struct packed {
        logic bits_zero;
        logic bits_one;
        logic lead_sign;
        logic pad_zero;
        logic pad_one;
        logic trail_sign;
        logic dig_zero;
        logic dig_one;
    } t_status;

    // Control store addresses
    localparam t_upc UPC_IDLE    = 4'd0;
    localparam t_upc UPC_CONV    = 4'd1;
    localparam t_upc UPC_DABBLE  = 4'd2;
    localparam t_upc UPC_COUNT   = 4'd3;
    localparam t_upc UPC_LEAD    = 4'd4;
    localparam t_upc UPC_LEAD_EM = 4'd5;
    localparam t_upc UPC_PAD     = 4'd6;
    localparam t_upc UPC_PAD_EM  = 4'd7;
    localparam t_upc UPC_TRAIL   = 4'd8;
    localparam t_upc UPC_TRL_EM  = 4'd9;
    localparam t_upc UPC_DIG     = 4'd10;
    localparam t_upc UPC_DIG_EM  = 4'd11;
    localparam t_upc UPC_DONE    = 4'd12;

endpackage

### rtl/itoaf_ucode_rom.sv
// Control store of the formatter sequencer.
module itoaf_ucode_rom (
    input  itoaf_pkg::t_upc   i_upc,
    output itoaf_pkg::t_uword o_uword
);

    always_comb begin
        unique case (i_upc)
            itoaf_pkg::UPC_IDLE:    o_uword = '{itoaf_pkg::OP_NOP,       itoaf_pkg::C_WAIT,
                                               itoaf_pkg::UPC_IDLE};
            itoaf_pkg::UPC_CONV:    o_uword = '{itoaf_pkg::OP_NOP,       itoaf_pkg::C_CONV_DONE,
                                               itoaf_pkg::UPC_COUNT};
            itoaf_pkg::UPC_DABBLE:  o_uword = '{itoaf_pkg::OP_DABBLE,    itoaf_pkg::C_BITS_LEFT,
                                               itoaf_pkg::UPC_DABBLE};
            itoaf_pkg::UPC_COUNT:   o_uword = '{itoaf_pkg::OP_COUNT,     itoaf_pkg::C_NONE,
                                               itoaf_pkg::UPC_IDLE};
            itoaf_pkg::UPC_LEAD:    o_uword = '{itoaf_pkg::OP_NOP,       itoaf_pkg::C_NO_LEAD,
                                               itoaf_pkg::UPC_PAD};
            itoaf_pkg::UPC_LEAD_EM: o_uword = '{itoaf_pkg::OP_EMIT_SIGN, itoaf_pkg::C_NONE,
                                               itoaf_pkg::UPC_IDLE};
            itoaf_pkg::UPC_PAD:     o_uword = '{itoaf_pkg::OP_NOP,       itoaf_pkg::C_PAD_ZERO,
                                               itoaf_pkg::UPC_TRAIL};
            itoaf_pkg::UPC_PAD_EM:  o_uword = '{itoaf_pkg::OP_EMIT_PAD,  itoaf_pkg::C_PAD_LEFT,
                                               itoaf_pkg::UPC_PAD_EM};
            itoaf_pkg::UPC_TRAIL:   o_uword = '{itoaf_pkg::OP_NOP,       itoaf_pkg::C_NO_TRAIL,
                                               itoaf_pkg::UPC_DIG};
            itoaf_pkg::UPC_TRL_EM:  o_uword = '{itoaf_pkg::OP_EMIT_SIGN, itoaf_pkg::C_NONE,
                                               itoaf_pkg::UPC_IDLE};
            itoaf_pkg::UPC_DIG:     o_uword = '{itoaf_pkg::OP_NOP,       itoaf_pkg::C_DIG_ZERO,
                                               itoaf_pkg::UPC_IDLE};
            itoaf_pkg::UPC_DIG_EM:  o_uword = '{itoaf_pkg::OP_EMIT_DIG,  itoaf_pkg::C_DIG_LEFT,
                                               itoaf_pkg::UPC_DIG_EM};
            itoaf_pkg::UPC_DONE:    o_uword = '{itoaf_pkg::OP_NOP,       itoaf_pkg::C_ALWAYS,
                                               itoaf_pkg::UPC_IDLE};
            default:                o_uword = '{itoaf_pkg::OP_NOP,       itoaf_pkg::C_ALWAYS,
                                               itoaf_pkg::UPC_IDLE};
        endcase
    end

endmodule

### rtl/itoaf_sequencer.sv
// Step counter and conditional jump logic of the formatter.
module itoaf_sequencer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  itoaf_pkg::t_status i_status,
    input  itoaf_pkg::t_uword i_uword,
    output itoaf_pkg::t_upc   o_upc
);

    itoaf_pkg::t_upc r_upc;
    itoaf_pkg::t_upc n_upc;
    logic            take;

    always_comb begin
        unique case (i_uword.cond)
            itoaf_pkg::C_NONE:      take = 1'b0;
            itoaf_pkg::C_ALWAYS:    take = 1'b1;
            itoaf_pkg::C_WAIT:      take = !i_start;
            itoaf_pkg::C_CONV_DONE: take = i_status.bits_zero;
            itoaf_pkg::C_BITS_LEFT: take = !i_status.bits_one;
            itoaf_pkg::C_NO_LEAD:   take = !i_status.lead_sign;
            itoaf_pkg::C_PAD_ZERO:  take = i_status.pad_zero;
            itoaf_pkg::C_PAD_LEFT:  take = !i_status.pad_one;
            itoaf_pkg::C_NO_TRAIL:  take = !i_status.trail_sign;
            itoaf_pkg::C_DIG_ZERO:  take = i_status.dig_zero;
            itoaf_pkg::C_DIG_LEFT:  take = !i_status.dig_one;
            default:                take = 1'b1;
        endcase
        n_upc = take ? i_uword.target : r_upc + 4'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= itoaf_pkg::UPC_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_upc = r_upc;

endmodule

### rtl/itoaf_datapath.sv
// Conversion registers, counters and character generation of the formatter.
module itoaf_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  itoaf_pkg::t_req    i_req,
    input  itoaf_pkg::t_op     i_op,
    output itoaf_pkg::t_status o_status,
    output logic               o_valid,
    output itoaf_pkg::t_res    o_res
);

    logic [itoaf_pkg::NUM_DIGITS-1:0][3:0] r_bcd, n_bcd, adj;
    logic [31:0] r_sh, n_sh;
    logic [5:0]  r_bits, n_bits;
    logic        r_neg, n_neg;
    logic        r_zf;
    logic [2:0]  r_func;
    logic [3:0]  r_width, n_width;
    logic [3:0]  r_nd, n_nd, cnt_nd;
    logic [3:0]  r_pad, n_pad;
    logic        r_valid, n_valid;
    itoaf_pkg::t_res r_res, n_res;
    logic [15:0] mag16;
    logic [31:0] mag32;
    logic [3:0]  dig_idx;
    logic [3:0]  nib;
    logic [7:0]  alpha;

    assign mag16   = i_req.value[15] ? 16'd0 - i_req.value[15:0] : i_req.value[15:0];
    assign mag32   = i_req.value[31] ? 32'd0 - i_req.value : i_req.value;
    assign dig_idx = r_nd - 4'd1;
    assign nib     = r_bcd[dig_idx];
    assign alpha   = (r_func == itoaf_pkg::FUNC_HEX_UP) ? itoaf_pkg::CH_UC_A : itoaf_pkg::CH_LC_A;

    // add-3 correction ahead of each shift
    always_comb begin
        for (int i = 0; i < itoaf_pkg::NUM_DIGITS; i++) begin
            adj[i] = (r_bcd[i] >= 4'd5) ? r_bcd[i] + 4'd3 : r_bcd[i];
        end
    end

    // digit count: highest non-zero digit, min one; byte 0 or 1, empty 0
    always_comb begin
        cnt_nd = 4'd1;
        for (int i = 0; i < itoaf_pkg::NUM_DIGITS; i++) begin
            if (r_bcd[i] != 4'd0) begin
                cnt_nd = 4'(i + 1);
            end
        end
        if (r_func == itoaf_pkg::FUNC_BYTE) begin
            cnt_nd = {3'd0, (r_bcd[1] != 4'd0) || (r_bcd[0] != 4'd0)};
        end else if (r_func > itoaf_pkg::FUNC_BYTE) begin
            cnt_nd = 4'd0;
        end
    end

    always_comb begin
        n_bcd   = r_bcd;
        n_sh    = r_sh;
        n_bits  = r_bits;
        n_neg   = r_neg;
        n_width = r_width;
        n_nd    = r_nd;
        n_pad   = r_pad;
        n_valid = 1'b0;
        n_res   = r_res;
        if (i_load) begin
            n_width = (i_req.width > itoaf_pkg::MAX_WIDTH) ? itoaf_pkg::MAX_WIDTH : i_req.width;
            n_neg   = 1'b0;
            n_bcd   = '0;
            n_sh    = '0;
            n_bits  = '0;
            unique case (i_req.func)
                itoaf_pkg::FUNC_S16: begin
                    n_neg  = i_req.value[15];
                    n_sh   = {mag16, 16'd0};
                    n_bits = itoaf_pkg::BITS_16;
                end
                itoaf_pkg::FUNC_S32: begin
                    n_neg  = i_req.value[31];
                    n_sh   = mag32;
                    n_bits = itoaf_pkg::BITS_32;
                end
                itoaf_pkg::FUNC_U16: begin
                    n_sh   = {i_req.value[15:0], 16'd0};
                    n_bits = itoaf_pkg::BITS_16;
                end
                itoaf_pkg::FUNC_HEX_LO, itoaf_pkg::FUNC_HEX_UP: begin
                    n_bcd = {8'd0, i_req.value};
                end
                itoaf_pkg::FUNC_BYTE: begin
                    n_bcd = {32'd0, i_req.value[7:0]};
                end
                default: begin
                    n_bcd = '0;
                end
            endcase
        end else begin
            unique case (i_op)
                itoaf_pkg::OP_DABBLE: begin
                    {n_bcd, n_sh} = {adj, r_sh} << 1;
                    n_bits        = r_bits - 6'd1;
                end
                itoaf_pkg::OP_COUNT: begin
                    n_nd  = cnt_nd;
                    n_pad = (r_width > cnt_nd) ? r_width - cnt_nd : 4'd0;
                end
                itoaf_pkg::OP_EMIT_SIGN: begin
                    n_valid = 1'b1;
                    n_res   = '{itoaf_pkg::CH_MINUS, (r_pad == 4'd0) && (r_nd == 4'd0)};
                    if (r_zf) begin
                        n_res.last = 1'b0;
                    end
                    if (!r_zf) begin
                        n_res.last = (r_nd == 4'd0);
                    end
                end
                itoaf_pkg::OP_EMIT_PAD: begin
                    n_valid  = 1'b1;
                    n_res.ch = r_zf ? itoaf_pkg::CH_ZERO : itoaf_pkg::CH_SPACE;
                    n_res.last = (r_pad == 4'd1) && !(r_neg && !r_zf) && (r_nd == 4'd0);
                    n_pad    = r_pad - 4'd1;
                end
                itoaf_pkg::OP_EMIT_DIG: begin
                    n_valid = 1'b1;
                    if (r_func == itoaf_pkg::FUNC_BYTE) begin
                        n_res.ch = {r_bcd[1], r_bcd[0]};
                    end else if (nib > 4'd9) begin
                        n_res.ch = {4'd0, nib} + alpha - 8'd10;
                    end else begin
                        n_res.ch = {4'd0, nib} + itoaf_pkg::CH_ZERO;
                    end
                    n_res.last = (r_nd == 4'd1);
                    n_nd       = r_nd - 4'd1;
                end
                default: begin
                    n_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_bcd   <= n_bcd;
        r_sh    <= n_sh;
        r_bits  <= n_bits;
        r_neg   <= n_neg;
        r_width <= n_width;
        r_nd    <= n_nd;
        r_pad   <= n_pad;
        r_res   <= n_res;
        if (i_load) begin
            r_zf   <= i_req.zero_fill;
            r_func <= i_req.func;
        end
    end

    assign o_status.bits_zero  = (r_bits == 6'd0);
    assign o_status.bits_one   = (r_bits == 6'd1);
    assign o_status.lead_sign  = r_neg && r_zf;
    assign o_status.pad_zero   = (r_pad == 4'd0);
    assign o_status.pad_one    = (r_pad == 4'd1);
    assign o_status.trail_sign = r_neg && !r_zf;
    assign o_status.dig_zero   = (r_nd == 4'd0);
    assign o_status.dig_one    = (r_nd == 4'd1);

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

### rtl/integer_to_ascii_formatter_unit.sv
// Top level of the integer to ASCII formatter: sequencer, control store and datapath.
//
//  channel  | ports                     | handshake
//  ---------+---------------------------+--------------------------------------
//  request  | i_req (t_req)             | taken at an edge with start & !busy
//  result   | o_res (t_res)             | o_valid high for one cycle, no stall
//
//  Steps: decimal kinds run one double-dabble step per input bit (16 or 32)
//  before the sign, padding and digits are emitted; hex, byte and empty kinds
//  skip the conversion loop and go straight to the digit count.
//  Reset (synchronous, active low) returns the step counter to idle and drops o_valid.
//  Results cannot be held off; busy stays high until the last character has gone.
module integer_to_ascii_formatter_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  itoaf_pkg::t_req   i_req,
    output logic              o_valid,
    output itoaf_pkg::t_res   o_res
);

    itoaf_pkg::t_upc    upc;
    itoaf_pkg::t_uword  uword;
    itoaf_pkg::t_status status;
    logic               accept;

    // busy whenever the program is away from its idle step
    assign busy   = (upc != itoaf_pkg::UPC_IDLE);
    assign accept = start && !busy;

    itoaf_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .i_uword  (uword),
        .o_upc    (upc)
    );

    itoaf_ucode_rom u_rom (
        .i_upc   (upc),
        .o_uword (uword)
    );

    itoaf_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_req    (i_req),
        .i_op     (uword.op),
        .o_status (status),
        .o_valid  (o_valid),
        .o_res    (o_res)
    );

    // a taken request always moves the program off idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("request taken but sequencer stayed idle");

    // final character of a run is never followed straight by another
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.last) |=> !o_valid)
        else $error("character directly after end of run");

    // a character other than the last of its run means the program has not yet returned to idle
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_res.last) |-> busy)
        else $error("character emitted while idle");

    // reset leaves the block idle with no output
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_valid))
        else $error("not idle after reset");

endmodule

### sim/itoaf_checker.sv
`timescale 1ns / 100ps
// Checker: predicts the characters of each accepted request and compares them with the output.
module itoaf_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_busy,
    input  itoaf_pkg::t_req i_req,
    input  logic            i_valid,
    input  itoaf_pkg::t_res i_res,
    output int              o_errors,
    output int              o_pending,
    output int              o_chars
);

    itoaf_pkg::t_res exp_chars[$];

    // Builds the expected character run of one request, padding and sign included.
    function automatic void predict_chars(input itoaf_pkg::t_req r);
        logic [7:0]      dig_q[$];
        logic [7:0]      run_q[$];
        logic [31:0]     mag;
        logic [31:0]     rem;
        logic [3:0]      nib;
        logic [3:0]      w;
        logic            neg;
        logic            dec;
        logic            hex;
        logic [7:0]      a_base;
        int              pad;
        itoaf_pkg::t_res res;
        neg    = 1'b0;
        dec    = 1'b0;
        hex    = 1'b0;
        mag    = '0;
        a_base = itoaf_pkg::CH_LC_A;
        case (r.func)
            itoaf_pkg::FUNC_S16: begin
                dec = 1'b1;
                if (r.value[15]) begin
                    neg = 1'b1;
                    mag = 32'h1_0000 - {16'h0, r.value[15:0]};
                end else begin
                    mag = {16'h0, r.value[15:0]};
                end
            end
            itoaf_pkg::FUNC_S32: begin
                dec = 1'b1;
                if (r.value[31]) begin
                    neg = 1'b1;
                    mag = 32'h0 - r.value;
                end else begin
                    mag = r.value;
                end
            end
            itoaf_pkg::FUNC_U16: begin
                dec = 1'b1;
                mag = {16'h0, r.value[15:0]};
            end
            itoaf_pkg::FUNC_HEX_LO: begin
                hex = 1'b1;
                mag = r.value;
            end
            itoaf_pkg::FUNC_HEX_UP: begin
                hex    = 1'b1;
                mag    = r.value;
                a_base = itoaf_pkg::CH_UC_A;
            end
            itoaf_pkg::FUNC_BYTE: begin
                // a zero byte gives only padding
                if (r.value[7:0] != 8'h00) dig_q.push_back(r.value[7:0]);
            end
            default: ;
        endcase
        if (dec) begin
            do begin
                rem = mag % 32'd10;
                dig_q.push_front(itoaf_pkg::CH_ZERO + rem[7:0]);
                mag = mag / 32'd10;
            end while (mag != 0);
        end
        if (hex) begin
            do begin
                nib = mag[3:0];
                if (nib > 4'd9) dig_q.push_front(a_base + {4'h0, nib} - 8'd10);
                else dig_q.push_front(itoaf_pkg::CH_ZERO + {4'h0, nib});
                mag = mag >> 4;
            end while (mag != 0);
        end
        w   = (r.width > itoaf_pkg::MAX_WIDTH) ? itoaf_pkg::MAX_WIDTH : r.width;
        pad = (int'(w) > dig_q.size()) ? int'(w) - dig_q.size() : 0;
        if (r.zero_fill && neg) run_q.push_back(itoaf_pkg::CH_MINUS);
        repeat (pad) run_q.push_back(r.zero_fill ? itoaf_pkg::CH_ZERO : itoaf_pkg::CH_SPACE);
        if (!r.zero_fill && neg) run_q.push_back(itoaf_pkg::CH_MINUS);
        foreach (dig_q[i]) run_q.push_back(dig_q[i]);
        foreach (run_q[i]) begin
            res.ch   = run_q[i];
            res.last = (i == run_q.size() - 1);
            exp_chars.push_back(res);
        end
    endfunction

    task automatic report_error(input string what, input itoaf_pkg::t_res want,
                                input itoaf_pkg::t_res got);
        o_errors++;
        if (o_errors <= 10)
            $display("%0t checker: %s: expected ch %02h last %0d, got ch %02h last %0d",
                     $time, what, want.ch, want.last, got.ch, got.last);
    endtask

    always @(posedge i_clk) begin
        itoaf_pkg::t_res want;
        if (i_rst_n) begin
            if (i_valid) begin
                o_chars++;
                if (exp_chars.size() == 0) begin
                    report_error("character with nothing outstanding", '0, i_res);
                end else begin
                    want = exp_chars.pop_front();
                    if (i_res.ch !== want.ch || i_res.last !== want.last)
                        report_error("character mismatch", want, i_res);
                end
            end
            if (i_start && !i_busy) predict_chars(i_req);
            o_pending = exp_chars.size();
        end
    end

endmodule

### sim/tb_integer_to_ascii_formatter_unit.sv
`timescale 1ns / 100ps
// Testbench top: drives format requests into the formatter and gives the verdict.
module tb_integer_to_ascii_formatter_unit;

    localparam int N_RANDOM     = 300;
    // watchdog bound, far above what the slowest request plus idling needs
    localparam int CYCLE_LIMIT  = 200000;
    // tail after the last character, covers one full conversion
    localparam int DRAIN_CYCLES = 64;

    logic            i_clk   = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            start   = 1'b0;
    itoaf_pkg::t_req i_req   = '0;
    logic            busy;
    logic            o_valid;
    itoaf_pkg::t_res o_res;

    int              errors;
    int              pending;
    int              chars_seen;
    int              sent   = 0;
    int              cycles = 0;
    itoaf_pkg::t_req directed[$];

    integer_to_ascii_formatter_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    itoaf_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_busy    (busy),
        .i_req     (i_req),
        .i_valid   (o_valid),
        .i_res     (o_res),
        .o_errors  (errors),
        .o_pending (pending),
        .o_chars   (chars_seen)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung sequencer must not hang the run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d characters outstanding", cycles, pending);
            $display("tb_integer_to_ascii_formatter_unit: done, errors");
            $finish;
        end
    end

    // Random request: values lean on sign boundaries, small numbers and zero bytes;
    // widths mostly legal with a few above nine; kind seven now and then.
    function automatic itoaf_pkg::t_req random_request();
        itoaf_pkg::t_req r;
        case ($urandom_range(0, 5))
            0: r.value = $urandom();
            1: r.value = $urandom_range(0, 20);
            2: begin
                case ($urandom_range(0, 5))
                    0: r.value = 32'h8000_0000;
                    1: r.value = 32'h7FFF_FFFF;
                    2: r.value = {16'($urandom_range(0, 65535)), 16'h8000};
                    3: r.value = {16'($urandom_range(0, 65535)), 16'h7FFF};
                    4: r.value = 32'hFFFF_FFFF;
                    default: r.value = {16'($urandom_range(0, 65535)), 16'hFFFF};
                endcase
            end
            3: r.value = {16'($urandom_range(0, 65535)),
                          16'(($urandom()) >> $urandom_range(0, 15))};
            4: r.value = {24'($urandom_range(0, 16777215)), 8'h00};
            default: r.value = $urandom() >> $urandom_range(0, 31);
        endcase
        r.func      = ($urandom_range(0, 99) < 5) ? itoaf_pkg::FUNC_RSVD
                                                  : 3'($urandom_range(0, 6));
        r.width     = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 9))
                                                   : 4'($urandom_range(10, 15));
        r.zero_fill = 1'($urandom_range(0, 1));
        return r;
    endfunction

    // Present one request and hold it until the block takes it.
    task automatic send_request(input itoaf_pkg::t_req r);
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sent++;
    endtask

    // Random idle cycles between requests, with junk on the request bus.
    task automatic idle_gaps();
        while ($urandom_range(0, 99) < 33) begin
            start <= 1'b0;
            i_req <= random_request();
            @(posedge i_clk);
        end
    endtask

    // Hold off until every predicted character has come out.
    task automatic drain_results();
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    initial begin
        // Directed requests: field extremes, every kind, negative extremes,
        // saturated widths, zero byte, empty kind, unused kind and empty runs.
        directed.push_back('{32'h0000_8000, itoaf_pkg::FUNC_S16, 4'd0, 1'b0}); // -32768
        directed.push_back('{32'hFFFF_7FFF, itoaf_pkg::FUNC_S16, 4'd9, 1'b1});
        directed.push_back('{32'hFFFF_FFFF, itoaf_pkg::FUNC_S16, 4'd5, 1'b1}); // -1, zero fill
        directed.push_back('{32'h0001_FFFF, itoaf_pkg::FUNC_S16, 4'd5, 1'b0}); // -1, spaces
        directed.push_back('{32'h0000_0000, itoaf_pkg::FUNC_S16, 4'd0, 1'b0});
        directed.push_back('{32'h8000_0000, itoaf_pkg::FUNC_S32, 4'd0, 1'b0}); // most negative
        directed.push_back('{32'h8000_0000, itoaf_pkg::FUNC_S32, 4'd9, 1'b1});
        directed.push_back('{32'h7FFF_FFFF, itoaf_pkg::FUNC_S32, 4'd9, 1'b1});
        directed.push_back('{32'hFFFF_FFFF, itoaf_pkg::FUNC_S32, 4'd9, 1'b0});
        directed.push_back('{32'h0000_0000, itoaf_pkg::FUNC_S32, 4'd15, 1'b1}); // saturates
        directed.push_back('{32'hFFFF_FFFF, itoaf_pkg::FUNC_U16, 4'd0, 1'b0});
        directed.push_back('{32'h0000_0000, itoaf_pkg::FUNC_U16, 4'd3, 1'b1});
        directed.push_back('{32'h1234_ABCD, itoaf_pkg::FUNC_U16, 4'd12, 1'b0});
        directed.push_back('{32'hDEAD_BEEF, itoaf_pkg::FUNC_HEX_LO, 4'd0, 1'b0});
        directed.push_back('{32'h0000_0000, itoaf_pkg::FUNC_HEX_LO, 4'd9, 1'b1});
        directed.push_back('{32'hABCD_EF01, itoaf_pkg::FUNC_HEX_UP, 4'd10, 1'b0});
        directed.push_back('{32'h0000_000F, itoaf_pkg::FUNC_HEX_UP, 4'd4, 1'b1});
        directed.push_back('{32'h5555_AA41, itoaf_pkg::FUNC_BYTE, 4'd0, 1'b0});
        directed.push_back('{32'hFFFF_FF00, itoaf_pkg::FUNC_BYTE, 4'd0, 1'b0}); // no characters
        directed.push_back('{32'h0000_0000, itoaf_pkg::FUNC_BYTE, 4'd9, 1'b1}); // padding only
        directed.push_back('{32'h0000_00FF, itoaf_pkg::FUNC_BYTE, 4'd3, 1'b0});
        directed.push_back('{32'hFFFF_FFFF, itoaf_pkg::FUNC_EMPTY, 4'd0, 1'b1}); // no characters
        directed.push_back('{32'h1234_5678, itoaf_pkg::FUNC_EMPTY, 4'd7, 1'b0});
        directed.push_back('{32'hFFFF_FFFF, itoaf_pkg::FUNC_RSVD, 4'd2, 1'b1}); // unused kind
        directed.push_back('{32'h0000_0000, itoaf_pkg::FUNC_RSVD, 4'd0, 1'b0});

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            send_request(directed[i]);
            idle_gaps();
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            // let the output run dry a couple of times mid-stream
            if (n == 40 || n == 230) drain_results();
            send_request(random_request());
            // requests 120 to 199 go back to back
            if (n < 120 || n >= 200) idle_gaps();
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests over every format kind, widths 0 to 15 and both fills",
                 sent);
        $display("%0d characters checked, %0d mismatches, %0d left outstanding",
                 chars_seen, errors, pending);
        if (errors == 0 && pending == 0) begin
            $display("tb_integer_to_ascii_formatter_unit: done, clean");
        end else begin
            $display("tb_integer_to_ascii_formatter_unit: done, errors");
        end
        $finish;
    end

endmodule

### integer_to_ascii_formatter_unit.f
rtl/itoaf_pkg.sv
rtl/itoaf_ucode_rom.sv
rtl/itoaf_sequencer.sv
rtl/itoaf_datapath.sv
rtl/integer_to_ascii_formatter_unit.sv
sim/itoaf_checker.sv
sim/tb_integer_to_ascii_formatter_unit.sv
